// ===== sv/bdil_pkg.sv =====
// ----------------------------------------------------------------------------
// bdil_pkg
// shared types and constants of the binary image dilation core
// ----------------------------------------------------------------------------
package bdil_pkg;

    // register file
    localparam int CFG_W             = 12;
    localparam int CFG_ADDR_W        = 1;
    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_MAX_HEIGHT    = 2048;
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(48);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(48);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // stream bus data width
    localparam int TDATA_W = 8;

    // result queue
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    typedef struct packed {
        logic frame_end;
        logic pixel_out;
    } t_result;

    // up to two results per cycle; push_b only together with push_a
    typedef struct packed {
        logic    push_a;
        logic    push_b;
        t_result res_a;
        t_result res_b;
    } t_push;

endpackage

// ===== sv/bdil_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bdil_out_fifo
// small result queue that takes up to two results per cycle and hands out one
// ----------------------------------------------------------------------------
module bdil_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdil_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output bdil_pkg::t_result o_result
);
    import bdil_pkg::*;

    t_result                r_buf [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_rd_ptr;
    logic [OFIFO_PTR_W-1:0] r_wr_ptr;
    logic [OFIFO_CNT_W-1:0] r_cnt;

    logic                   w_pop;
    logic [OFIFO_CNT_W-1:0] w_level;
    logic [OFIFO_CNT_W-1:0] n_cnt;
    logic [OFIFO_PTR_W-1:0] n_wr_ptr;

    assign o_valid  = (r_cnt != '0);
    assign o_result = r_buf[r_rd_ptr];
    assign w_pop    = o_valid & i_ready;

    // room for a full pair after this cycle's pop
    assign w_level = r_cnt - OFIFO_CNT_W'(w_pop);
    assign o_room  = (w_level <= OFIFO_CNT_W'(OFIFO_DEPTH - 2));

    assign n_cnt    = r_cnt + OFIFO_CNT_W'(i_push.push_a) + OFIFO_CNT_W'(i_push.push_b)
                      - OFIFO_CNT_W'(w_pop);
    assign n_wr_ptr = r_wr_ptr + OFIFO_PTR_W'(i_push.push_a) + OFIFO_PTR_W'(i_push.push_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_PTR_W'(1);
            end
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_buf[r_wr_ptr] <= i_push.res_a;
        end
        if (i_push.push_b) begin
            r_buf[OFIFO_PTR_W'(r_wr_ptr + OFIFO_PTR_W'(1))] <= i_push.res_b;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push_b |-> i_push.push_a)
        else $error("second result pushed without first");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OFIFO_CNT_W'(OFIFO_DEPTH))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push_a |=> o_valid)
        else $error("pushed result not visible");

endmodule

// ===== sv/binary_image_dilation_core.sv =====
// ----------------------------------------------------------------------------
// binary_image_dilation_core
// streaming 3x3 binary dilation without the centre column, one row of latency
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                     | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser: kind, tdata[0]: pixel_in
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata[0]: pixel_out, tlast: frame_end
//  cfg       | in        | i_cfg_we (no wait)            | i_cfg_addr, i_cfg_wdata
//
//  one input item per clock while the result queue has room; an item is held
//  in the stage register between the line buffer read and the result queue
//  the line buffer is a single memory, one read and one write port, with a
//  forward path for a write and a read to the same column in one cycle
//  reset is synchronous; the line buffer is not cleared, entries are used
//  only after being written in the current frame
//  s_axis stalls only while the result queue cannot take a pair of results
// ----------------------------------------------------------------------------
module binary_image_dilation_core #(
    parameter int MAX_WIDTH  = bdil_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bdil_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [bdil_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bdil_pkg::CFG_W-1:0]     i_cfg_wdata,
    // source stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bdil_pkg::TDATA_W-1:0]   s_axis_tdata,   // [0] pixel_in
    input  logic                           s_axis_tuser,   // [0] kind
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bdil_pkg::TDATA_W-1:0]   m_axis_tdata,   // [0] pixel_out
    output logic                           m_axis_tlast
);
    import bdil_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // index of the last row or column for a register value, the size clamped to 1..mx
    function automatic logic [31:0] f_last_idx(input logic [CFG_W-1:0] v,
                                               input logic [31:0] mx);
        logic [31:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > mx) begin
            res = mx - 32'd1;
        end else begin
            res = 32'(v) - 32'd1;
        end
        return res;
    endfunction

    // line buffer entry: [1] row r-2, [0] row r-1
    logic [1:0]     r_line [MAX_WIDTH];
    logic [1:0]     r_rd_q;
    logic           r_byp;
    logic [1:0]     r_byp_data;

    // configuration and frame position
    logic [CW-1:0]  r_col_last;
    logic [RW-1:0]  r_row_last;
    logic [CW-1:0]  r_col;          // column of the next pixel, or of the next drain output
    logic [RW-1:0]  r_row;
    logic           r_drain;

    // stage register
    logic           r_s1_valid;
    logic           r_s1_flush;
    logic           r_s1_pix;
    logic [CW-1:0]  r_s1_col;
    logic           r_s1_c0;
    logic           r_s1_clast;
    logic           r_s1_rge1;
    logic           r_s1_rge2;

    // neighborhood history
    logic           r_win1;         // any set in column c-1
    logic           r_win2;         // any set in column c-2
    logic           r_dr1;          // drain: column d
    logic           r_dr2;          // drain: column d-1

    logic           w_is_flush;
    logic           w_take;
    logic           w_s1_move;
    logic           w_room;
    logic [CW-1:0]  w_rd_addr;
    logic [1:0]     w_rd;
    logic           w_a;
    logic           w_b;
    logic           w_v_any;
    logic           w_prev1;
    logic           w_prev2;
    logic [1:0]     w_wr_data;
    logic           w_mem_we;
    logic           w_en0;
    logic           w_en1;
    logic           w_res0;
    logic           w_res1;
    logic           w_nxt;
    t_push          w_push;
    t_result        w_out;

    assign w_is_flush    = (s_axis_tuser == KIND_FLUSH);
    assign s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_take        = s_axis_tvalid && s_axis_tready && (w_is_flush == r_drain);
    assign w_s1_move     = r_s1_valid && w_room;
    assign w_rd_addr     = r_drain ? CW'(r_col + CW'(1)) : r_col;

    // ---- frame position and configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= CW'(f_last_idx(RST_IMAGE_WIDTH, 32'(MAX_WIDTH)));
            r_row_last <= RW'(f_last_idx(RST_IMAGE_HEIGHT, 32'(MAX_HEIGHT)));
            r_col      <= '0;
            r_row      <= '0;
            r_drain    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_IMAGE_WIDTH: begin
                    r_col_last <= CW'(f_last_idx(i_cfg_wdata, 32'(MAX_WIDTH)));
                end
                REG_IMAGE_HEIGHT: begin
                    r_row_last <= RW'(f_last_idx(i_cfg_wdata, 32'(MAX_HEIGHT)));
                end
                default: begin
                end
            endcase
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= 1'b0;
        end else if (w_take) begin
            if (r_col == r_col_last) begin
                r_col <= '0;
                if (r_drain) begin
                    r_drain <= 1'b0;
                end else if (r_row == r_row_last) begin
                    r_row   <= '0;
                    r_drain <= 1'b1;
                end else begin
                    r_row <= r_row + RW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---- stage register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_flush <= r_drain;
            r_s1_pix   <= s_axis_tdata[0];
            r_s1_col   <= r_col;
            r_s1_c0    <= (r_col == '0);
            r_s1_clast <= (r_col == r_col_last);
            r_s1_rge1  <= (r_row != '0);
            r_s1_rge2  <= (r_row > RW'(1));
            r_byp      <= w_mem_we && (r_s1_col == w_rd_addr);
            r_byp_data <= w_wr_data;
        end
    end

    // ---- line buffer ----
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_line[r_s1_col] <= w_wr_data;
        end
        if (w_take) begin
            r_rd_q <= r_line[w_rd_addr];
        end
    end

    assign w_rd = r_byp ? r_byp_data : r_rd_q;

    // ---- stage logic ----
    assign w_a       = r_s1_rge2 & w_rd[1];
    assign w_b       = r_s1_rge1 & w_rd[0];
    assign w_v_any   = w_a | w_b | r_s1_pix;
    assign w_prev1   = !r_s1_c0 & r_win1;
    assign w_prev2   = !r_s1_c0 & r_win2;
    assign w_wr_data = {w_b, r_s1_pix};
    assign w_mem_we  = w_s1_move && !r_s1_flush;

    assign w_en0  = r_s1_rge1 & !r_s1_c0;
    assign w_en1  = r_s1_rge1 & r_s1_clast;
    assign w_res0 = w_prev2 | w_v_any;
    assign w_res1 = w_prev1;

    // column d+1 beyond the row reads as clear
    assign w_nxt = !r_s1_clast & (w_rd[1] | w_rd[0]);

    always_comb begin
        w_push = '0;
        if (w_s1_move) begin
            if (r_s1_flush) begin
                w_push.push_a          = 1'b1;
                w_push.res_a.pixel_out = r_dr2 | w_nxt;
                w_push.res_a.frame_end = r_s1_clast;
            end else begin
                w_push.push_a          = w_en0 | w_en1;
                w_push.push_b          = w_en0 & w_en1;
                w_push.res_a.pixel_out = w_en0 ? w_res0 : w_res1;
                w_push.res_b.pixel_out = w_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win1 <= 1'b0;
            r_win2 <= 1'b0;
            r_dr1  <= 1'b0;
            r_dr2  <= 1'b0;
        end else if (w_s1_move) begin
            if (r_s1_flush) begin
                r_dr2 <= r_dr1;
                r_dr1 <= w_nxt;
            end else begin
                r_win2 <= w_prev1;
                r_win1 <= w_v_any;
                // column 0 of each row primes the drain history
                if (r_s1_c0) begin
                    r_dr1 <= w_b | r_s1_pix;
                    r_dr2 <= 1'b0;
                end
            end
        end
    end

    // ---- result queue ----
    bdil_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out)
    );

    assign m_axis_tdata = {{(TDATA_W-1){1'b0}}, w_out.pixel_out};
    assign m_axis_tlast = w_out.frame_end;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_col_last)
        else $error("column position past end of row");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_row_last)
        else $error("row position past end of frame");

    a_drain_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_row == '0))
        else $error("draining with a nonzero row position");

    a_flush_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_drain) |=> (r_s1_valid && r_s1_flush))
        else $error("accepted flush not staged");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming binary dilation core: a short scripted
// sequence and then random frames of many sizes are pushed through the source
// stream, every result is compared against a scripted expectation or an in-bench model of the dilation
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdil_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int TARGET_ITEMS = 1800;
    localparam int DRAIN_PAUSE  = 12;
    localparam int TAIL_CYCLES  = 20;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PREDICT      = -1;
    localparam int EXTREME_CUT  = 300;

    localparam t_result QUIET_PX      = '{frame_end: 1'b0, pixel_out: 1'b0};
    localparam t_result LAST_QUIET_PX = '{frame_end: 1'b1, pixel_out: 1'b0};

    typedef enum {ROW_WRITE_W, ROW_WRITE_H, ROW_PIXEL, ROW_FLUSH} t_row_op;
    typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_HOLD} t_rx_mode;

    typedef struct {
        t_row_op          op;
        logic [CFG_W-1:0] value;
        logic             pix;
        int               fixed_n;
        t_result          fixed_res;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;

    // dilation model state
    logic [CFG_W-1:0] width_reg  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0] height_reg = RST_IMAGE_HEIGHT;
    bit               older_px [MAX_W];
    bit               newer_px [MAX_W];
    logic [5:0]       window;
    int               row_idx;
    int               col_idx;
    int               drain_col;

    t_result dilated_due [$];
    int      mismatches;
    int      quiet_cycles;

    // sender pacing and per-request typed expectation
    int      burst_left;
    bit      bursty = 1'b1;
    int      held_fixed_n = PREDICT;
    t_result held_fixed_res;

    t_script_row script [25] = '{
        '{ROW_FLUSH,   12'd0,    1'b1, 0,       QUIET_PX},   // nothing to drain after reset
        '{ROW_PIXEL,   12'd0,    1'b1, 0,       QUIET_PX},   // first row only fills the buffer
        '{ROW_WRITE_W, 12'd3,    1'b0, PREDICT, QUIET_PX},
        '{ROW_WRITE_H, 12'd2,    1'b0, PREDICT, QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b1, 0,       QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b0, 0,       QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b0, 0,       QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b0, PREDICT, QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b0, PREDICT, QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b1, PREDICT, QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b1, 0,       QUIET_PX},   // pixel during drain is dropped
        '{ROW_FLUSH,   12'd0,    1'b0, PREDICT, QUIET_PX},
        '{ROW_FLUSH,   12'd0,    1'b1, PREDICT, QUIET_PX},
        '{ROW_FLUSH,   12'd0,    1'b0, PREDICT, QUIET_PX},
        '{ROW_FLUSH,   12'd0,    1'b0, 0,       QUIET_PX},   // frame already closed
        '{ROW_WRITE_W, 12'd0,    1'b0, PREDICT, QUIET_PX},   // zero size acts as one
        '{ROW_WRITE_H, 12'd0,    1'b0, PREDICT, QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b1, 0,       QUIET_PX},
        '{ROW_FLUSH,   12'd0,    1'b0, 1,       LAST_QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b1, 0,       QUIET_PX},
        '{ROW_FLUSH,   12'd0,    1'b1, 1,       LAST_QUIET_PX},
        '{ROW_WRITE_H, 12'd4095, 1'b0, PREDICT, QUIET_PX},   // clamps to the largest height
        '{ROW_PIXEL,   12'd0,    1'b1, 0,       QUIET_PX},
        '{ROW_PIXEL,   12'd0,    1'b1, 1,       QUIET_PX},   // one column has no neighbors
        '{ROW_PIXEL,   12'd0,    1'b0, 1,       QUIET_PX}
    };

    binary_image_dilation_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [0] pixel_in
        .s_axis_tuser  (s_axis_tuser),   // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] pixel_out
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fit_size(input logic [CFG_W-1:0] value, input int max_size);
        if (value == 0) return 1;
        if (int'(value) > max_size) return max_size;
        return int'(value);
    endfunction

    function automatic void restart_frame();
        window    = '0;
        row_idx   = 0;
        col_idx   = 0;
        drain_col = 0;
    endfunction

    function automatic logic column_or(input int col, input int w, input bit with_older);
        if (col >= w) return 1'b0;
        return newer_px[col] | (with_older & older_px[col]);
    endfunction

    // advances the model by one request, returns how many pixels it releases
    function automatic int dilate_item(input logic kind, input logic pix,
                                       output t_result res [2]);
        int         w;
        int         h;
        int         d;
        int         r;
        int         c;
        int         n;
        logic       v_or;
        logic [2:0] col_bits;
        logic [2:0] prev1;
        logic [2:0] prev2;
        w = fit_size(width_reg, MAX_W);
        h = fit_size(height_reg, MAX_H);
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (kind == KIND_FLUSH) begin
            if (drain_col == 0) return 0;
            d = drain_col - 1;
            v_or = column_or(d + 1, w, h >= 2);
            if (d >= 1) v_or |= column_or(d - 1, w, h >= 2);
            res[0].pixel_out = v_or;
            res[0].frame_end = (d + 1 >= w);
            if (d + 1 >= w) restart_frame();
            else drain_col++;
            return 1;
        end
        if (drain_col != 0) return 0;
        r = row_idx;
        c = col_idx;
        // column vector: rows r-2, r-1, r from low bit up
        col_bits = {pix, (r >= 1) ? logic'(newer_px[c]) : 1'b0,
                         (r >= 2) ? logic'(older_px[c]) : 1'b0};
        older_px[c] = col_bits[1];
        newer_px[c] = pix;
        if (c == 0) window = '0;
        prev1 = window[2:0];
        prev2 = window[5:3];
        if (r >= 1) begin
            if (c >= 1) begin
                res[n] = '{frame_end: 1'b0, pixel_out: |{prev2, col_bits}};
                n++;
            end
            if (c + 1 >= w) begin
                res[n] = '{frame_end: 1'b0, pixel_out: |prev1};
                n++;
            end
        end
        window = {prev1, col_bits};
        if (c + 1 >= w) begin
            col_idx = 0;
            if (r + 1 >= h) begin
                row_idx   = 0;
                drain_col = 1;
            end else begin
                row_idx = r + 1;
            end
        end else begin
            col_idx = c + 1;
        end
        return n;
    endfunction

    // model update and result check, all on the rising edge
    always @(posedge i_clk) begin
        t_result fresh [2];
        t_result want;
        int      n;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_we) begin
                if (t_reg_idx'(i_cfg_addr) == REG_IMAGE_WIDTH) width_reg = i_cfg_wdata;
                else height_reg = i_cfg_wdata;
                restart_frame();
                quiet_cycles = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n = dilate_item(s_axis_tuser, s_axis_tdata[0], fresh);
                if (held_fixed_n >= 0) begin
                    n = held_fixed_n;
                    fresh[0] = held_fixed_res;
                end
                for (int k = 0; k < n; k++) dilated_due.push_back(fresh[k]);
                quiet_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                if (dilated_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %0h tlast %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    want = dilated_due.pop_front();
                    if (m_axis_tdata !== TDATA_W'(want.pixel_out)) begin
                        $display("%0t: pixel_out mismatch, expected %0h actual %0h",
                                 $time, TDATA_W'(want.pixel_out), m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $display("%0t: frame_end mismatch, expected %0b actual %0b",
                                 $time, want.frame_end, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        t_rx_mode mode;
        int       span;
        m_axis_tready = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = (mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 40);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:   m_axis_tready = 1'b1;
                    RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_axis_tready = ($urandom_range(0, 3) != 0);
                    default:   m_axis_tready = 1'b0;
                endcase
            end
        end
    end

    task automatic send_item(input logic kind, input logic pix,
                             input int fixed_n = PREDICT, input t_result fixed_res = '0);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (bursty) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid  = 1'b1;
        s_axis_tuser   = kind;
        s_axis_tdata   = TDATA_W'(pix);
        held_fixed_n   = fixed_n;
        held_fixed_res = fixed_res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // returns at a falling edge once every pending pixel is out
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (dilated_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx sel, input logic [CFG_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = sel;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int               phase;
        int               useful;
        int               n_frames;
        int               cut;
        int               density;
        int               which;
        int               sel;
        int               w;
        int               h;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        logic [CFG_W-1:0] gen_w;
        logic [CFG_W-1:0] gen_h;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_IMAGE_WIDTH;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PIXEL;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[i]) begin
            case (script[i].op)
                ROW_WRITE_W: begin
                    wait_idle();
                    write_reg(REG_IMAGE_WIDTH, script[i].value);
                end
                ROW_WRITE_H: begin
                    wait_idle();
                    write_reg(REG_IMAGE_HEIGHT, script[i].value);
                end
                ROW_PIXEL: send_item(KIND_PIXEL, script[i].pix, script[i].fixed_n,
                                     script[i].fixed_res);
                default:   send_item(KIND_FLUSH, script[i].pix, script[i].fixed_n,
                                     script[i].fixed_res);
            endcase
        end

        // first phases pin the size extremes, the rest are small random frames
        phase  = 0;
        useful = 0;
        gen_w  = '0;
        gen_h  = '0;
        while (phase < 5 || useful < TARGET_ITEMS) begin
            case (phase)
                0:       begin wv = 12'd4095; hv = 12'd1;    end
                1:       begin wv = 12'd1;    hv = 12'd4095; end
                2:       begin wv = 12'd2;    hv = 12'd1;    end
                3:       begin wv = 12'd0;    hv = 12'd2;    end
                4:       begin wv = CFG_W'($urandom_range(2, 6)); hv = 12'd0; end
                default: begin
                    sel = $urandom_range(0, 19);
                    if (sel < 15)      wv = CFG_W'($urandom_range(1, 9));
                    else if (sel < 18) wv = CFG_W'($urandom_range(10, 48));
                    else               wv = 12'd0;
                    hv = ($urandom_range(0, 9) == 0) ? 12'd0 : CFG_W'($urandom_range(1, 7));
                end
            endcase
            wait_idle();
            which = (phase < 5) ? 2 : $urandom_range(0, 2);
            if (which == 1) wv = gen_w;
            else write_reg(REG_IMAGE_WIDTH, wv);
            if (which == 0) hv = gen_h;
            else write_reg(REG_IMAGE_HEIGHT, hv);
            gen_w  = wv;
            gen_h  = hv;
            w      = fit_size(wv, MAX_W);
            h      = fit_size(hv, MAX_H);
            bursty = ($urandom_range(0, 3) != 0);
            n_frames = (w * h > 200) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                case ($urandom_range(0, 3))
                    0:       density = 10;
                    1:       density = 35;
                    2:       density = 60;
                    default: density = 90;
                endcase
                // now and then a frame is abandoned and the next write restarts it
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h + w - 1) : -1;
                // the widest and the tallest frame are only started
                if (phase < 2) cut = EXTREME_CUT;
                for (int k = 0; k < w * h + w; k++) begin
                    if (k == cut) break;
                    if ($urandom_range(0, 24) == 0)
                        send_item((k < w * h) ? KIND_FLUSH : KIND_PIXEL,
                                  1'($urandom_range(0, 1)));
                    if (k < w * h)
                        send_item(KIND_PIXEL, ($urandom_range(0, 99) < density));
                    else
                        send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
                    useful++;
                end
                if (cut >= 0) break;
            end
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
